// ===== src/ovls_pkg.sv =====
// ovls_pkg: types and constants shared by the ordered value list store
// holds item structs, opcode and status codes, and cell command struct
// no dependencies

package ovls_pkg;

  // list size default and fixed field widths
  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int POS_W         = 5;
  localparam int TOTAL_W       = 5;

  // operation codes carried by an input item
  typedef enum logic [2:0] {
    OP_PUSH_FRONT   = 3'd0,
    OP_INSERT_AT    = 3'd1,
    OP_PUSH_BACK    = 3'd2,
    OP_CLEAR        = 3'd3,
    OP_POP_BACK     = 3'd4,
    OP_REMOVE_VALUE = 3'd5
  } op_t;

  // status codes returned with every result
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // input item
  typedef struct packed {
    op_t                       opcode;
    logic signed [DATA_W-1:0]  data_value;
    logic        [POS_W-1:0]   insert_position;
  } in_item_t;

  // result item
  typedef struct packed {
    status_t                   status;
    logic        [TOTAL_W-1:0] entry_total;
  } out_item_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                      ins_en;
    logic                      del_en;
    logic        [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

// ===== src/ovls_cell.sv =====
// ovls_cell: one slot of the list, holds a single stored value
// shifts toward either neighbor on insert or remove; uses ovls_pkg

module ovls_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  logic                           clk,
  input  ovls_pkg::cell_cmd_t            cmd,
  input  logic [CW-1:0]                  count,
  input  logic [CW-1:0]                  ins_pos,
  input  logic [ovls_pkg::DATA_W-1:0]    left_value,
  input  logic [ovls_pkg::DATA_W-1:0]    right_value,
  input  logic                           drop_in,
  output logic                           drop_out,
  output logic [ovls_pkg::DATA_W-1:0]    value
);

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  logic [ovls_pkg::DATA_W-1:0] value_r;
  logic [ovls_pkg::DATA_W-1:0] value_nxt;
  logic                        occupied;
  logic                        match;

  // slot holds a live entry when it sits below the count
  assign occupied = IDX < count;
  assign match    = cmd.del_en && occupied && (value_r == cmd.value);

  // once the first match is seen every later slot pulls from the right
  assign drop_out = drop_in || match;

  // next value: shift right on insert, load, shift left on remove
  always_comb begin
    value_nxt = value_r;
    if (cmd.ins_en && (IDX > ins_pos)) begin
      value_nxt = left_value;
    end else if (cmd.ins_en && (IDX == ins_pos)) begin
      value_nxt = cmd.value;
    end else if (drop_out) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// ===== src/ordered_value_list_store.sv =====
// ordered_value_list_store: top level of the ordered value list store
// row of ovls_cell slots plus count and result register; uses ovls_pkg
//
// usage:
//   in_valid/in_ready/in_data carry one item: an opcode, a signed value
//   and an insert position. out_valid/out_ready/out_data return exactly
//   one result per item: a status and the entry count after the item.
//   every item finishes in the clock edge that accepts it: all slots
//   compare against the value and shift toward a neighbor at once, with
//   the first-match flag rippling along the row of slots.
//   out_valid rises in the cycle after acceptance; a new item is
//   taken every cycle as long as the result register is empty or is
//   being drained in the same cycle (throughput one item per cycle).
//   when the receiver stalls, the result register holds and in_ready
//   drops until the result is taken.
//   reset (rst_n low, synchronous) empties the list and drops out_valid;
//   slot contents are not cleared, entries past the count are never read.
//   entry_total carries the low five bits of the count.

module ordered_value_list_store #(
  parameter int DEPTH = ovls_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ovls_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ovls_pkg::out_item_t out_data
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > ovls_pkg::POS_W) ? CW : ovls_pkg::POS_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic                         accept;
  logic [CW-1:0]                count_r;
  logic [CW-1:0]                count_nxt;
  logic                         full;
  logic                         empty;
  logic                         is_insert;
  logic [CW-1:0]                ins_pos;
  logic                         found;
  ovls_pkg::status_t            status;
  ovls_pkg::cell_cmd_t          cmd;
  logic                         out_valid_r;
  ovls_pkg::out_item_t          out_data_r;

  logic [ovls_pkg::DATA_W-1:0]  slot_value [DEPTH];
  logic                         drop_chain [DEPTH+1];

  // handshake: take an item when the result register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign full  = (count_r == FULL_COUNT);
  assign empty = (count_r == '0);

  assign is_insert = (in_data.opcode == ovls_pkg::OP_PUSH_FRONT) ||
                     (in_data.opcode == ovls_pkg::OP_INSERT_AT)  ||
                     (in_data.opcode == ovls_pkg::OP_PUSH_BACK);

  // insert slot: front, back, or given position clamped to the count
  always_comb begin
    if (in_data.opcode == ovls_pkg::OP_PUSH_FRONT) begin
      ins_pos = '0;
    end else if ((in_data.opcode == ovls_pkg::OP_PUSH_BACK) ||
                 (CMPW'(in_data.insert_position) >= CMPW'(count_r))) begin
      ins_pos = count_r;
    end else begin
      ins_pos = CW'(in_data.insert_position);
    end
  end

  // command broadcast to the row
  assign cmd.ins_en = accept && is_insert && !full;
  assign cmd.del_en = accept && (in_data.opcode == ovls_pkg::OP_REMOVE_VALUE) && !empty;
  assign cmd.value  = in_data.data_value;

  // row of slots, each talking to its two neighbors
  assign drop_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ovls_pkg::DATA_W-1:0] left_v;
    logic [ovls_pkg::DATA_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = slot_value[i];
    end else begin : g_mid_l
      assign left_v = slot_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_v = slot_value[i];
    end else begin : g_mid_r
      assign right_v = slot_value[i+1];
    end

    ovls_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count_r),
      .ins_pos     (ins_pos),
      .left_value  (left_v),
      .right_value (right_v),
      .drop_in     (drop_chain[i]),
      .drop_out    (drop_chain[i+1]),
      .value       (slot_value[i])
    );
  end

  assign found = drop_chain[DEPTH];

  // next count and status for the item
  always_comb begin
    count_nxt = count_r;
    status    = ovls_pkg::ST_OK;
    unique case (in_data.opcode)
      ovls_pkg::OP_PUSH_FRONT,
      ovls_pkg::OP_INSERT_AT,
      ovls_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status = ovls_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      ovls_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      ovls_pkg::OP_POP_BACK: begin
        if (empty) begin
          status = ovls_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      ovls_pkg::OP_REMOVE_VALUE: begin
        if (empty) begin
          status = ovls_pkg::ST_EMPTY;
        end else if (!found) begin
          status = ovls_pkg::ST_NOT_FOUND;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.status      <= status;
      out_data_r.entry_total <= ovls_pkg::TOTAL_W'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
